@@ hdl/sbsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsi_pkg
// Shared widths, defaults and codes for the segment/box slab intersect block.
// ----------------------------------------------------------------------------
package sbsi_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = COORD_W + 1;
    localparam int IN_DW   = 12 * COORD_W;
    localparam int OUT_DW  = 104;
    localparam int FACE_W  = 3;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;
    localparam int POINT_FRAC_BITS_DEF = 12;

    typedef enum logic [FACE_W-1:0] {
        FACE_NONE,
        FACE_NEG_Y,
        FACE_POS_Y,
        FACE_NEG_X,
        FACE_POS_X,
        FACE_NEG_Z,
        FACE_POS_Z
    } face_t;

endpackage

@@ hdl/sbsi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsi_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module sbsi_div
    import sbsi_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
    localparam int QB = PARAM_FRAC_BITS + 2,
    localparam int XW = PARAM_FRAC_BITS + 34,
    localparam int RW = DIR_W + QB
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [XW-1:0]     num,
    input  logic [DIR_W-1:0]  den,
    input  logic              neg_in,
    output logic [QB-1:0]     quo,
    output logic              ovf,
    output logic              neg_out
);

    logic [RW-1:0]    rem_reg [QB];
    logic [DIR_W-1:0] den_reg [QB];
    logic [QB-1:0]    quo_reg [QB+1];
    logic             ovf_reg [QB+1];
    logic             neg_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= RW'(num) >= (RW'(den) << QB);
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [RW-1:0] sub;
        logic          take;
        logic [QB-1:0] quo_next;

        assign sub  = RW'(den_reg[k-1]) << (QB - k);
        assign take = rem_reg[k-1] >= sub;

        always_comb
        begin
            quo_next = quo_reg[k-1];
            quo_next[QB-k] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_next;
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end

        if (k < QB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_reg[k-1] - sub) : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo     = quo_reg[QB];
    assign ovf     = ovf_reg[QB];
    assign neg_out = neg_reg[QB];

endmodule

@@ hdl/segment_box_slab_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_slab_intersect
// Slab test of a segment against an axis-aligned box, entry point and face.
// ----------------------------------------------------------------------------
// channel   dir  signals                         content
// s_axis    in   tvalid tready tdata[383:0]      box min xyz, box max xyz,
//                                                seg start xyz, seg end xyz
// m_axis    out  tvalid tready tdata[103:0] tuser  point xyz, face; hit
//
// One item per cycle while the skid buffer is empty; the pipeline depth is set
// by the six dividers, one quotient bit per stage.
// A one-entry skid buffer after the output register takes a result when the
// sink stalls; the whole pipeline holds while the skid buffer is full.
// rst_n clears the valid bits and the skid buffer's valid flag only.
// ----------------------------------------------------------------------------
module segment_box_slab_intersect
    import sbsi_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
    parameter int POINT_FRAC_BITS = POINT_FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z
    input  logic [IN_DW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // point_x, point_y, point_z, face_code, zero pad
    output logic [OUT_DW-1:0] m_axis_tdata,
    // hit
    output logic [0:0]        m_axis_tuser
);

    localparam int QB  = PARAM_FRAC_BITS + 2;
    localparam int XW  = PARAM_FRAC_BITS + 34;
    localparam int LW  = PARAM_FRAC_BITS + 1;
    localparam int TW  = PARAM_FRAC_BITS + 3;
    localparam int PW  = DIR_W + LW + 1;
    localparam int EW  = PARAM_FRAC_BITS + 36;
    localparam int NST = QB + 7;
    localparam int PE  = (POINT_FRAC_BITS < COORD_FRAC_BITS) ? POINT_FRAC_BITS
                                                              : COORD_FRAC_BITS;
    localparam int SH  = PARAM_FRAC_BITS + COORD_FRAC_BITS - PE;
    localparam int UP  = COORD_FRAC_BITS - PE;

    localparam logic [LW-1:0] T_ONE = LW'(1) << PARAM_FRAC_BITS;
    localparam logic [LW-1:0] T_CAP = T_ONE + LW'(1);
    localparam logic signed [EW-1:0] P_MAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] P_MIN = -P_MAX - EW'(1);
    localparam logic signed [EW-1:0] R_HALF = EW'(1) <<< (SH - 1);

    typedef struct packed {
        logic [2:0][COORD_W-1:0] bmin;
        logic [2:0][COORD_W-1:0] bmax;
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][DIR_W-1:0]   d;
        logic [2:0]              dz;
        logic [2:0]              zpass;
    } side_t;

    typedef struct packed {
        logic                    hit;
        logic [2:0][COORD_W-1:0] point;
        face_t                   face;
    } res_t;

    function automatic logic [DIR_W-1:0] mag(input logic [DIR_W-1:0] v);
        return v[DIR_W-1] ? (~v + DIR_W'(1)) : v;
    endfunction

    // ---------------- flow control ----------------
    logic [NST-1:0] valid_reg;
    logic           skid_valid_reg;
    res_t           skid_reg;
    res_t           out_reg;
    logic           en;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[NST-2:0], s_axis_tvalid};
                if (valid_reg[NST-1] && !m_axis_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_reg[NST-1] && !m_axis_tready)
        begin
            skid_reg <= out_reg;
        end
    end

    // ---------------- input and prep stages ----------------
    logic [IN_DW-1:0] in_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    side_t            a_side_next, a_side_reg;
    logic [XW-1:0]    a_num_next [6];
    logic [XW-1:0]    a_num_reg  [6];
    logic [DIR_W-1:0] a_den_next [3];
    logic [DIR_W-1:0] a_den_reg  [3];
    logic             a_neg_next [6];
    logic             a_neg_reg  [6];

    always_comb
    begin
        logic signed [COORD_W-1:0] bmin, bmax, s, e;
        logic [DIR_W-1:0]          d, n0, n1, dm;
        for (int i = 0; i < 3; i++)
        begin
            bmin = $signed(in_data_reg[COORD_W*i +: COORD_W]);
            bmax = $signed(in_data_reg[COORD_W*(3+i) +: COORD_W]);
            s    = $signed(in_data_reg[COORD_W*(6+i) +: COORD_W]);
            e    = $signed(in_data_reg[COORD_W*(9+i) +: COORD_W]);
            d    = {e[COORD_W-1], e} - {s[COORD_W-1], s};
            n0   = {bmin[COORD_W-1], bmin} - {s[COORD_W-1], s};
            n1   = {bmax[COORD_W-1], bmax} - {s[COORD_W-1], s};
            dm   = mag(d);
            a_side_next.bmin[i]  = bmin;
            a_side_next.bmax[i]  = bmax;
            a_side_next.s[i]     = s;
            a_side_next.d[i]     = d;
            a_side_next.dz[i]    = (d == '0);
            a_side_next.zpass[i] = (s >= bmin && s <= bmax) || (s >= bmax && s <= bmin);
            a_den_next[i]     = dm;
            a_num_next[2*i]   = XW'({mag(n0), {PARAM_FRAC_BITS{1'b0}}}) + XW'(dm >> 1);
            a_num_next[2*i+1] = XW'({mag(n1), {PARAM_FRAC_BITS{1'b0}}}) + XW'(dm >> 1);
            a_neg_next[2*i]   = n0[DIR_W-1] ^ d[DIR_W-1];
            a_neg_next[2*i+1] = n1[DIR_W-1] ^ d[DIR_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= a_side_next;
            a_num_reg  <= a_num_next;
            a_den_reg  <= a_den_next;
            a_neg_reg  <= a_neg_next;
        end
    end

    // ---------------- dividers and side delay ----------------
    logic [QB-1:0] dv_quo [6];
    logic          dv_ovf [6];
    logic          dv_neg [6];

    for (genvar k = 0; k < 6; k++)
    begin : g_div
        sbsi_div #(
            .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     (a_num_reg[k]),
            .den     (a_den_reg[k/2]),
            .neg_in  (a_neg_reg[k]),
            .quo     (dv_quo[k]),
            .ovf     (dv_ovf[k]),
            .neg_out (dv_neg[k])
        );
    end

    side_t dly_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= a_side_reg;
            for (int k = 1; k <= QB; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // ---------------- interval clip ----------------
    side_t          c_side_reg;
    logic [LW-1:0]  c_lo_next, c_lo_reg;
    logic           c_hit_next, c_hit_reg;

    always_comb
    begin
        logic [LW-1:0]     qs;
        logic signed [TW-1:0] t [6];
        logic signed [TW-1:0] lo_ax, hi_ax, lo, hi;
        lo = '0;
        hi = $signed({2'b00, T_ONE});
        for (int k = 0; k < 6; k++)
        begin
            qs = (dv_ovf[k] || dv_quo[k] > QB'(T_CAP)) ? T_CAP : dv_quo[k][LW-1:0];
            if (dv_neg[k])
            begin
                t[k] = (qs == '0) ? TW'(0) : -TW'(1);
            end
            else
            begin
                t[k] = $signed({2'b00, qs});
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            lo_ax = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
            hi_ax = (t[2*i] < t[2*i+1]) ? t[2*i+1] : t[2*i];
            if (!dly_reg[QB].dz[i])
            begin
                if (lo_ax > lo)
                begin
                    lo = lo_ax;
                end
                if (hi_ax < hi)
                begin
                    hi = hi_ax;
                end
            end
        end
        c_lo_next  = lo[LW-1:0];
        c_hit_next = (&(~dly_reg[QB].dz | dly_reg[QB].zpass)) && (lo <= hi);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= dly_reg[QB];
            c_lo_reg   <= c_lo_next;
            c_hit_reg  <= c_hit_next;
        end
    end

    // ---------------- multiply ----------------
    logic signed [PW-1:0] m_prod_reg [3];
    side_t                m_side_reg;
    logic                 m_hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_prod_reg[i] <= $signed(c_side_reg.d[i]) * $signed({1'b0, c_lo_reg});
            end
            m_side_reg <= c_side_reg;
            m_hit_reg  <= c_hit_reg;
        end
    end

    // ---------------- round and saturate ----------------
    logic [2:0][COORD_W-1:0] r_point_next, r_point_reg;
    logic [2:0][COORD_W-1:0] r_bmin_reg, r_bmax_reg;
    logic                    r_hit_reg;

    always_comb
    begin
        logic signed [EW-1:0] sum, r;
        for (int i = 0; i < 3; i++)
        begin
            sum = (EW'($signed(m_side_reg.s[i])) <<< PARAM_FRAC_BITS)
                + EW'(m_prod_reg[i]) + R_HALF;
            r   = (sum >>> SH) <<< UP;
            if (r > P_MAX)
            begin
                r_point_next[i] = P_MAX[COORD_W-1:0];
            end
            else if (r < P_MIN)
            begin
                r_point_next[i] = P_MIN[COORD_W-1:0];
            end
            else
            begin
                r_point_next[i] = r[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_point_reg <= r_point_next;
            r_bmin_reg  <= m_side_reg.bmin;
            r_bmax_reg  <= m_side_reg.bmax;
            r_hit_reg   <= m_hit_reg;
        end
    end

    // ---------------- face select and output ----------------
    res_t out_next;

    always_comb
    begin
        face_t face;
        if (r_point_reg[1] == r_bmin_reg[1])
            face = FACE_NEG_Y;
        else if (r_point_reg[1] == r_bmax_reg[1])
            face = FACE_POS_Y;
        else if (r_point_reg[0] == r_bmin_reg[0])
            face = FACE_NEG_X;
        else if (r_point_reg[0] == r_bmax_reg[0])
            face = FACE_POS_X;
        else if (r_point_reg[2] == r_bmin_reg[2])
            face = FACE_NEG_Z;
        else if (r_point_reg[2] == r_bmax_reg[2])
            face = FACE_POS_Z;
        else
            face = FACE_NONE;
        if (r_hit_reg)
        begin
            out_next.hit   = 1'b1;
            out_next.point = r_point_reg;
            out_next.face  = face;
        end
        else
        begin
            out_next.hit   = 1'b0;
            out_next.point = '0;
            out_next.face  = FACE_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    res_t shown;

    assign shown         = skid_valid_reg ? skid_reg : out_reg;
    assign m_axis_tvalid = skid_valid_reg || valid_reg[NST-1];
    assign m_axis_tuser  = shown.hit;
    assign m_axis_tdata  = {{(OUT_DW - 3*COORD_W - FACE_W){1'b0}}, shown.face,
                            shown.point[2], shown.point[1], shown.point[0]};

    // ---------------- checks ----------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss result carries nonzero fields");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && valid_reg[NST-1] && !m_axis_tready |=> skid_valid_reg)
        else $error("stalled result not captured by skid buffer");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid buffer changed while stalled");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the segment/box slab intersect block against a behavioral predictor:
// a directed table of corner cases, then random boxes and segments, with
// random stalls on both stream sides and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sbsi_pkg::*;

    localparam int CF = COORD_FRAC_BITS_DEF;
    localparam int PF = PARAM_FRAC_BITS_DEF;
    localparam int QF = POINT_FRAC_BITS_DEF;
    localparam int LATENCY = PF + 8;
    localparam int N_RANDOM = 680;

    typedef logic signed [31:0] coord_t;

    typedef struct {
        coord_t bmin [3];
        coord_t bmax [3];
        coord_t s0 [3];
        coord_t s1 [3];
    } query_t;

    typedef struct {
        logic   hit;
        coord_t pt [3];
        face_t  face;
    } isect_t;

    typedef struct {
        query_t q;
        bit     has_exp;
        isect_t exp;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_DW-1:0]   s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_DW-1:0]  m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    isect_t pending_isect [$];
    isect_t pinned_isect [$];
    int     n_errors;
    int     n_hits;
    int     n_misses;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    row_t   rows [$];

    segment_box_slab_intersect dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("segment_box_slab_intersect test failed");
        $finish;
    end

    function automatic longint slab_param(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = (num < 0 ? -num : num) <<< PF;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic coord_t snap_coord(longint s, longint e, longint t);
        int pe;
        int sh;
        longint ex;
        longint r;
        pe = QF < CF ? QF : CF;
        sh = PF + CF - pe;
        ex = s * (longint'(1) <<< PF) + (e - s) * t;
        r = (ex + (longint'(1) <<< (sh - 1))) >>> sh;
        r = r * (longint'(1) <<< (CF - pe));
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return coord_t'(r);
    endfunction

    function automatic isect_t slab_intersect(query_t q);
        isect_t r;
        longint lo;
        longint hi;
        longint d;
        longint a;
        longint b;
        longint t0;
        longint t1;
        longint tmp;
        bit     miss;
        r.hit = 1'b0;
        r.face = FACE_NONE;
        for (int i = 0; i < 3; i++)
            r.pt[i] = '0;
        lo = 0;
        hi = longint'(1) <<< PF;
        miss = 0;
        for (int i = 0; i < 3 && !miss; i++)
        begin
            d = longint'(q.s1[i]) - longint'(q.s0[i]);
            if (d == 0)
            begin
                a = q.bmin[i] < q.bmax[i] ? q.bmin[i] : q.bmax[i];
                b = q.bmin[i] < q.bmax[i] ? q.bmax[i] : q.bmin[i];
                miss = !(q.s0[i] >= a && q.s0[i] <= b);
            end
            else
            begin
                t0 = slab_param(longint'(q.bmin[i]) - q.s0[i], d);
                t1 = slab_param(longint'(q.bmax[i]) - q.s0[i], d);
                if (t1 < t0)
                begin
                    tmp = t0;
                    t0 = t1;
                    t1 = tmp;
                end
                if (t0 > lo)
                    lo = t0;
                if (t1 < hi)
                    hi = t1;
                miss = lo > hi;
            end
        end
        if (miss)
            return r;
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++)
            r.pt[i] = snap_coord(q.s0[i], q.s1[i], lo);
        if (r.pt[1] == q.bmin[1])
            r.face = FACE_NEG_Y;
        else if (r.pt[1] == q.bmax[1])
            r.face = FACE_POS_Y;
        else if (r.pt[0] == q.bmin[0])
            r.face = FACE_NEG_X;
        else if (r.pt[0] == q.bmax[0])
            r.face = FACE_POS_X;
        else if (r.pt[2] == q.bmin[2])
            r.face = FACE_NEG_Z;
        else if (r.pt[2] == q.bmax[2])
            r.face = FACE_POS_Z;
        return r;
    endfunction

    function automatic bit same_isect(isect_t a, isect_t b);
        bit same;
        same = (a.hit === b.hit) && (a.face === b.face);
        for (int i = 0; i < 3; i++)
            if (a.pt[i] !== b.pt[i])
                same = 0;
        return same;
    endfunction

    function automatic logic [IN_DW-1:0] pack_query(query_t q);
        logic [IN_DW-1:0] v;
        for (int i = 0; i < 3; i++)
        begin
            v[32*i +: 32]       = q.bmin[i];
            v[32*(3+i) +: 32]   = q.bmax[i];
            v[32*(6+i) +: 32]   = q.s0[i];
            v[32*(9+i) +: 32]   = q.s1[i];
        end
        return v;
    endfunction

    function automatic query_t make_query(coord_t b0x, coord_t b0y, coord_t b0z,
                                          coord_t b1x, coord_t b1y, coord_t b1z,
                                          coord_t sx, coord_t sy, coord_t sz,
                                          coord_t ex, coord_t ey, coord_t ez);
        query_t q;
        q.bmin = '{b0x, b0y, b0z};
        q.bmax = '{b1x, b1y, b1z};
        q.s0 = '{sx, sy, sz};
        q.s1 = '{ex, ey, ez};
        return q;
    endfunction

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000;
            2:       return coord_t'($urandom_range(0, 40)) * 32'sh0000_4000
                            - 32'sh0005_0000;
            default: return coord_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000
                            : $urandom_range(0, 1) ? 32'h7fff_ffff : $urandom);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     m;
        m = $urandom_range(0, 9);
        m = m < 1 ? 0 : m < 2 ? 3 : m < 5 ? 2 : 1;
        for (int i = 0; i < 3; i++)
        begin
            q.bmin[i] = rand_coord(m);
            q.bmax[i] = rand_coord(m);
            if ($urandom_range(0, 5) != 0 && q.bmin[i] > q.bmax[i])
            begin
                q.bmin[i] ^= q.bmax[i];
                q.bmax[i] ^= q.bmin[i];
                q.bmin[i] ^= q.bmax[i];
            end
            q.s0[i] = rand_coord(m);
            q.s1[i] = $urandom_range(0, 5) == 0 ? q.s0[i] : rand_coord(m);
        end
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic send_query(query_t q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= pack_query(q);
        s_axis_tvalid <= 1'b1;
        pending_isect.insert(pending_isect.size(), slab_intersect(q));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_isect.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        isect_t want;
        isect_t pin;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_isect.size() == 0)
                report_mismatch("unexpected transfer", 0, 0);
            else
            begin
                want = pending_isect.pop_front();
                pin = want;
                if (pinned_isect.size() != 0)
                    pin = pinned_isect.pop_front();
                if (!same_isect(pin, want))
                    report_mismatch("table vs predictor", pin.hit, want.hit);
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", m_axis_tuser[0], want.hit);
                else if (want.hit)
                    n_hits++;
                else
                    n_misses++;
                for (int i = 0; i < 3; i++)
                    if (m_axis_tdata[32*i +: 32] !== want.pt[i])
                        report_mismatch($sformatf("point[%0d]", i),
                                        m_axis_tdata[32*i +: 32], want.pt[i]);
                if (m_axis_tdata[96 +: 3] !== want.face)
                    report_mismatch("face_code", m_axis_tdata[96 +: 3], want.face);
                if (m_axis_tdata[OUT_DW-1:99] !== '0)
                    report_mismatch("pad", m_axis_tdata[OUT_DW-1:99], 0);
            end
        end
    end

    initial
    begin
        row_t   r;
        isect_t e;
        int     idle_sets [3][2];
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        n_errors = 0;
        n_hits = 0;
        n_misses = 0;
        hold_cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 59;
        idle_sets = '{'{13, 59}, '{59, 13}, '{0, 0}};

        // through a unit box along x: enters at -x face
        e.hit = 1; e.pt = '{32'sh0000_0000, 32'sh0000_8000, 32'sh0000_8000};
        e.face = FACE_NEG_X;
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         -32'sh10000, 32'sh8000, 32'sh8000,
                         32'sh20000, 32'sh8000, 32'sh8000);
        r.has_exp = 1; r.exp = e; rows.insert(rows.size(), r);
        // start inside: point is the start, no face
        e.pt = '{32'sh8000, 32'sh8000, 32'sh8000}; e.face = FACE_NONE;
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh8000, 32'sh8000, 32'sh8000,
                         32'sh30000, 32'sh30000, 32'sh30000);
        r.exp = e; rows.insert(rows.size(), r);
        // clean miss, zero direction outside slab
        e.hit = 0; e.pt = '{0, 0, 0}; e.face = FACE_NONE;
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh20000, 32'sh8000, 32'sh8000,
                         32'sh20000, 32'sh9000, 32'sh9000);
        r.exp = e; rows.insert(rows.size(), r);
        // segment stops short of the box
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         -32'sh30000, 32'sh8000, 32'sh8000,
                         -32'sh10000, 32'sh8000, 32'sh8000);
        r.exp = e; rows.insert(rows.size(), r);
        r.has_exp = 0;
        // down along y hits +y, up hits -y, along z
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh8000, 32'sh30000, 32'sh8000, 32'sh8000, -32'sh10000, 32'sh8000);
        rows.insert(rows.size(), r);
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh8000, -32'sh10000, 32'sh8000, 32'sh8000, 32'sh30000, 32'sh8000);
        rows.insert(rows.size(), r);
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh8000, 32'sh8000, 32'sh30000, 32'sh8000, 32'sh8000, -32'sh10000);
        rows.insert(rows.size(), r);
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh8000, 32'sh8000, -32'sh10000, 32'sh8000, 32'sh8000, 32'sh30000);
        rows.insert(rows.size(), r);
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh30000, 32'sh8000, 32'sh8000, -32'sh10000, 32'sh8000, 32'sh8000);
        rows.insert(rows.size(), r);
        // inverted box on every axis
        r.q = make_query(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0,
                         -32'sh10000, 32'sh4000, 32'sh4000, 32'sh20000, 32'sh9000, 32'sh3000);
        rows.insert(rows.size(), r);
        // zero direction on the bound, zero-length segment, degenerate box
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         32'sh10000, 0, 32'sh8000, 32'sh10000, 0, 32'sh8000);
        rows.insert(rows.size(), r);
        r.q = make_query(32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000,
                         0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
        rows.insert(rows.size(), r);
        // grazing a corner, odd rounding
        r.q = make_query(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
                         -32'sh10000, -32'sh10000, 32'sh8000, 32'sh10000, 32'sh10000, 32'sh8001);
        rows.insert(rows.size(), r);
        r.q = make_query(0, 0, 0, 32'sh30000, 32'sh30000, 32'sh30000,
                         -32'sh1, 32'sh1234, 32'sh7, 32'sh30003, 32'sh2ffff, 32'sh2abcd);
        rows.insert(rows.size(), r);
        // full-range extremes and saturation
        r.q = make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        rows.insert(rows.size(), r);
        r.q = make_query(32'h7fff_f000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 0,
                         32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        rows.insert(rows.size(), r);
        r.q = make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        rows.insert(rows.size(), r);
        r.q = make_query(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                         32'h7fff_fff0, 32'h8000_0010, 32'h5555_5555,
                         32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa);
        rows.insert(rows.size(), r);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[k])
        begin
            if (rows[k].has_exp)
                pinned_isect.insert(pinned_isect.size(), rows[k].exp);
            else
                pinned_isect.insert(pinned_isect.size(), slab_intersect(rows[k].q));
            send_query(rows[k].q);
        end
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = idle_sets[p][0];
            recv_idle_pct = idle_sets[p][1];
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                if (p == 0 && k == 50)
                    hold_cycles <= 4 * LATENCY;
                if (k == 120)
                    wait_drained();
                send_query(rand_query());
            end
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d hits and %0d misses, incl. degenerate, inverted and extreme boxes",
                 n_hits, n_misses);
        if (n_errors == 0)
            $display("segment_box_slab_intersect test passed");
        else
            $display("segment_box_slab_intersect test failed");
        $finish;
    end
endmodule
